[hdl/smf_pkg.sv]
package smf_pkg;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int CFG_W  = 6;

    // Default window capacity and register reset value
    localparam int            MAX_WINDOW_DEF = 32;
    localparam logic [CFG_W-1:0] LEN_RESET   = 6'd5;

    // Sequencer states, one-hot
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_OLD  = 8'b0000_0010,
        S_DEL  = 8'b0000_0100,
        S_INS  = 8'b0000_1000,
        S_RBRD = 8'b0001_0000,
        S_RBV  = 8'b0010_0000,
        S_MED  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

endpackage

[hdl/smf_ram.sv]
module smf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, registered read port (old data on a same-address collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sliding_median_filter.sv]
// Sliding window median filter. Each request on the slave stream carries one
// signed 32-bit sample; one result follows on the master stream: the lower
// median of the last L samples, L being the window_length register (0 acts
// as 1, values above MAX_WINDOW act as MAX_WINDOW). The samples sit in a
// circular store memory and a second memory keeps the same L values in
// ascending order. For a regular sample, one pass over the sorted memory
// removes the oldest value and a second pass shifts the new one into place,
// both paced by the single read port of that memory. The first sample after
// reset and the first after any write of window_length rebuild the sorted
// memory from the store by insertion. The input is taken only while the filter
// is idle; a finished median waits in the output register while the next
// sample is taken.
module sliding_median_filter #(
    parameter int MAX_WINDOW = smf_pkg::MAX_WINDOW_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [smf_pkg::CFG_W-1:0]      i_cfg_wr_data,  // window_length
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [smf_pkg::DATA_W-1:0]     s_axis_tdata,   // [31:0] sample
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [smf_pkg::DATA_W-1:0]     m_axis_tdata    // [31:0] median
);

    import smf_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int PW = AW + 1;

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_len;
    logic                r_dirty, n_dirty;
    logic [AW-1:0]       r_pos, n_pos;
    logic [DATA_W-1:0]   r_key, n_key;
    logic [DATA_W-1:0]   r_old, n_old;
    logic                r_oldv, n_oldv;
    logic [MAX_WINDOW-1:0] r_vld, n_vld;
    logic [AW-1:0]       r_ridx, n_ridx;
    logic [AW-1:0]       r_didx, n_didx;
    logic                r_rv, n_rv;
    logic                r_iss, n_iss;
    logic                r_found, n_found;
    logic                r_tail, n_tail;
    logic [AW-1:0]       r_k, n_k;
    logic                r_rb, n_rb;
    logic [DATA_W-1:0]   r_out, n_out;
    logic                r_ovld, n_ovld;

    logic [LW-1:0]       len_eff;
    logic [LW-1:0]       len_m1_w;
    logic [AW-1:0]       len_m1;
    logic [AW-1:0]       med_idx;
    logic [PW-1:0]       pos_inc;

    logic                st_we, st_re;
    logic [AW-1:0]       st_waddr, st_raddr;
    logic [DATA_W-1:0]   st_wdata, st_rdata;
    logic                sr_we, sr_re;
    logic [AW-1:0]       sr_waddr, sr_raddr;
    logic [DATA_W-1:0]   sr_wdata, sr_rdata;

    logic                ins_go, ins_done;
    logic [AW-1:0]       ins_sz;

    // Window store, indexed by arrival position
    smf_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // Same window contents kept in ascending signed order
    smf_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_WINDOW)
    ) u_sorted (
        .i_clk   (i_clk),
        .i_we    (sr_we),
        .i_waddr (sr_waddr),
        .i_wdata (sr_wdata),
        .i_re    (sr_re),
        .i_raddr (sr_raddr),
        .o_rdata (sr_rdata)
    );

    // Clamp the register to 1..MAX_WINDOW
    always_comb begin
        if (r_len == '0) begin
            len_eff = LW'(1);
        end else if (int'(r_len) > MAX_WINDOW) begin
            len_eff = LW'(MAX_WINDOW);
        end else begin
            len_eff = LW'(r_len);
        end
    end

    assign len_m1_w = len_eff - LW'(1);
    assign len_m1   = len_m1_w[AW-1:0];
    assign med_idx  = len_m1 >> 1;
    assign pos_inc  = PW'(r_pos) + PW'(1);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_dirty  = r_dirty;
        n_pos    = r_pos;
        n_key    = r_key;
        n_old    = r_old;
        n_oldv   = r_oldv;
        n_vld    = r_vld;
        n_ridx   = r_ridx;
        n_didx   = r_didx;
        n_rv     = r_rv;
        n_iss    = r_iss;
        n_found  = r_found;
        n_tail   = r_tail;
        n_k      = r_k;
        n_rb     = r_rb;
        n_out    = r_out;
        n_ovld   = r_ovld;
        st_we    = 1'b0;
        st_re    = 1'b0;
        st_waddr = r_pos;
        st_raddr = r_pos;
        st_wdata = s_axis_tdata;
        sr_we    = 1'b0;
        sr_re    = 1'b0;
        sr_waddr = '0;
        sr_raddr = r_ridx;
        sr_wdata = '0;
        ins_go   = 1'b0;
        ins_sz   = '0;
        ins_done = 1'b0;

        // Drop the result once the master side takes it
        if (r_ovld && m_axis_tready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    // Write the sample, fetch the value it replaces
                    st_we  = 1'b1;
                    st_re  = 1'b1;
                    n_oldv = r_vld[r_pos];
                    n_vld[r_pos] = 1'b1;
                    n_key  = s_axis_tdata;
                    if (pos_inc >= PW'(len_eff)) begin
                        n_pos = '0;
                    end else begin
                        n_pos = pos_inc[AW-1:0];
                    end
                    if (r_dirty) begin
                        n_rb    = 1'b1;
                        n_k     = '0;
                        n_state = S_RBRD;
                    end else begin
                        n_rb    = 1'b0;
                        n_state = S_OLD;
                    end
                end
            end

            S_OLD: begin
                // Latch the evicted value, start the removal pass
                n_old   = r_oldv ? st_rdata : '0;
                n_ridx  = '0;
                n_iss   = 1'b1;
                n_rv    = 1'b0;
                n_found = 1'b0;
                n_state = S_DEL;
            end

            S_DEL: begin
                // Issue ascending reads
                n_rv = r_iss;
                if (r_iss) begin
                    sr_re    = 1'b1;
                    sr_raddr = r_ridx;
                    n_didx   = r_ridx;
                    if (r_ridx == len_m1) begin
                        n_iss = 1'b0;
                    end else begin
                        n_ridx = r_ridx + AW'(1);
                    end
                end
                // Close the gap left by the evicted value
                if (r_rv) begin
                    if (r_found) begin
                        sr_we    = 1'b1;
                        sr_waddr = r_didx - AW'(1);
                        sr_wdata = sr_rdata;
                    end else if (sr_rdata == r_old) begin
                        n_found = 1'b1;
                    end
                    if (r_didx == len_m1) begin
                        ins_go = 1'b1;
                        ins_sz = len_m1;
                    end
                end
            end

            S_INS: begin
                if (r_tail) begin
                    // New value is the smallest so far
                    sr_we    = 1'b1;
                    sr_waddr = '0;
                    sr_wdata = r_key;
                    ins_done = 1'b1;
                end else begin
                    // Issue descending reads
                    n_rv = r_iss;
                    if (r_iss) begin
                        sr_re    = 1'b1;
                        sr_raddr = r_ridx;
                        n_didx   = r_ridx;
                        if (r_ridx == '0) begin
                            n_iss = 1'b0;
                        end else begin
                            n_ridx = r_ridx - AW'(1);
                        end
                    end
                    // Shift larger values up, drop the key into the hole
                    if (r_rv) begin
                        sr_we    = 1'b1;
                        sr_waddr = r_didx + AW'(1);
                        if ($signed(sr_rdata) > $signed(r_key)) begin
                            sr_wdata = sr_rdata;
                            if (r_didx == '0) begin
                                n_tail = 1'b1;
                                n_rv   = 1'b0;
                            end
                        end else begin
                            sr_wdata = r_key;
                            ins_done = 1'b1;
                        end
                    end
                end
            end

            S_RBRD: begin
                // Fetch the next store entry for the rebuild
                st_re    = 1'b1;
                st_raddr = r_k;
                n_state  = S_RBV;
            end

            S_RBV: begin
                n_key  = r_vld[r_k] ? st_rdata : '0;
                ins_go = 1'b1;
                ins_sz = r_k;
            end

            S_MED: begin
                sr_re    = 1'b1;
                sr_raddr = med_idx;
                n_state  = S_DONE;
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!r_ovld || m_axis_tready) begin
                    n_out   = sr_rdata;
                    n_ovld  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Start an insertion into a sorted prefix of ins_sz entries
        if (ins_go) begin
            n_state = S_INS;
            n_rv    = 1'b0;
            if (ins_sz == '0) begin
                n_tail = 1'b1;
                n_iss  = 1'b0;
            end else begin
                n_tail = 1'b0;
                n_iss  = 1'b1;
                n_ridx = ins_sz - AW'(1);
            end
        end

        // Advance the rebuild or go read the median
        if (ins_done) begin
            n_tail = 1'b0;
            n_rv   = 1'b0;
            n_iss  = 1'b0;
            if (r_rb && (r_k != len_m1)) begin
                n_k     = r_k + AW'(1);
                n_state = S_RBRD;
            end else begin
                if (r_rb) begin
                    n_dirty = 1'b0;
                end
                n_state = S_MED;
            end
        end

        // A new length invalidates the sorted copy
        if (i_cfg_wr_en) begin
            n_dirty = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= LEN_RESET;
            r_dirty <= 1'b1;
            r_pos   <= '0;
            r_vld   <= '0;
            r_rv    <= 1'b0;
            r_iss   <= 1'b0;
            r_found <= 1'b0;
            r_tail  <= 1'b0;
            r_rb    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
            r_dirty <= n_dirty;
            r_pos   <= n_pos;
            r_vld   <= n_vld;
            r_rv    <= n_rv;
            r_iss   <= n_iss;
            r_found <= n_found;
            r_tail  <= n_tail;
            r_rb    <= n_rb;
            r_ovld  <= n_ovld;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_old  <= n_old;
        r_oldv <= n_oldv;
        r_ridx <= n_ridx;
        r_didx <= n_didx;
        r_k    <= n_k;
        r_out  <= n_out;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_out;

endmodule

[dv/sliding_median_filter_tb.sv]
`timescale 1ns / 1ps

module sliding_median_filter_tb;
    import smf_pkg::*;

    localparam int WIN_DEPTH   = MAX_WINDOW_DEF;
    localparam int CLK_HALF    = 5;
    localparam int SETTLE_CYC  = 2 * WIN_DEPTH + 16;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 75;
    localparam int MAX_REPORTS = 10;
    localparam int SRC_IDLE    = 47;
    localparam int SINK_STALL  = 47;
    localparam int BOTH_IDLE   = 28;

    typedef enum int {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SINK,
        IDLE_BOTH
    } t_idle_mode;

    // Tracks the sample window and queues the lower median for each request
    class median_scoreboard;
        logic [DATA_W-1:0] window_mem [WIN_DEPTH];
        int unsigned       wr_pos;
        logic [CFG_W-1:0]  len_reg;
        logic [DATA_W-1:0] median_q [$];
        int unsigned       n_samples;
        int unsigned       n_checked;
        int unsigned       n_errors;

        function new();
            foreach (window_mem[i]) window_mem[i] = '0;
            wr_pos    = 0;
            len_reg   = LEN_RESET;
            n_samples = 0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function void set_length(logic [CFG_W-1:0] value);
            len_reg = value;
        endfunction

        function int unsigned pending();
            return median_q.size();
        endfunction

        // Zero acts as one, anything above the store depth saturates
        function int unsigned eff_length();
            if (len_reg == 0) return 1;
            if (len_reg > WIN_DEPTH) return WIN_DEPTH;
            return 32'(len_reg);
        endfunction

        // Store the sample, advance the position, queue the lower median
        function void note_sample(logic [DATA_W-1:0] sample);
            logic signed [DATA_W-1:0] sorted [WIN_DEPTH];
            logic signed [DATA_W-1:0] key;
            int unsigned              len;
            int                       j;
            len = eff_length();
            if (wr_pos >= WIN_DEPTH) wr_pos = 0;
            window_mem[wr_pos] = sample;
            wr_pos++;
            // position may sit past a lowered length; wrap it either way
            if (wr_pos >= len) wr_pos = 0;
            for (int i = 0; i < len; i++) sorted[i] = window_mem[i];
            for (int i = 1; i < len; i++) begin
                key = sorted[i];
                j   = i;
                while (j > 0 && key < sorted[j-1]) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = key;
            end
            median_q.push_back(sorted[(len-1)/2]);
            n_samples++;
        endfunction

        // Compare one accepted result with the oldest queued median
        function void check_median(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (median_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected median %0d with none pending", $signed(got));
                return;
            end
            want = median_q.pop_front();
            n_checked++;
            if (got !== want) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("median mismatch on result %0d: expected %0d, got %0d",
                             n_checked, $signed(want), $signed(got));
            end
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;   // [31:0] sample
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b1;
    logic [DATA_W-1:0] m_axis_tdata;         // [31:0] median

    int unsigned       src_idle_pct   = 0;
    int unsigned       sink_stall_pct = 0;
    int unsigned       n_settings     = 0;

    median_scoreboard  sb = new();

    sliding_median_filter #(
        .MAX_WINDOW (WIN_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Stall the result side at random
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Record accepted requests and check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_median(m_axis_tdata);
        end
    end

    function automatic void set_idle(input t_idle_mode mode);
        unique case (mode)
            IDLE_NONE: begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            IDLE_SRC: begin
                src_idle_pct   = SRC_IDLE;
                sink_stall_pct = 0;
            end
            IDLE_SINK: begin
                src_idle_pct   = 0;
                sink_stall_pct = SINK_STALL;
            end
            default: begin
                src_idle_pct   = BOTH_IDLE;
                sink_stall_pct = BOTH_IDLE;
            end
        endcase
    endfunction

    // Mix of full-range values, small values with many ties, and extremes
    function automatic logic [DATA_W-1:0] rand_sample();
        logic [DATA_W-1:0] v;
        case ($urandom_range(3))
            0: begin
                v = $urandom_range(8);
                v = v - 32'd4;
            end
            1: begin
                case ($urandom_range(3))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0000;
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Drive one request, with random idle cycles ahead of it
    task automatic push_sample(input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = value;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Hold until every queued median has come back
    task automatic wait_drain();
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] value);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        sb.set_length(value);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        n_settings++;
    endtask

    initial begin
        logic [DATA_W-1:0] edge_vals  [8];
        logic [DATA_W-1:0] short_vals [4];
        logic [DATA_W-1:0] zero_vals  [3];
        logic [DATA_W-1:0] sat_vals   [5];
        logic [CFG_W-1:0]  phase_len  [RAND_PHASES];

        edge_vals  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                       32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001};
        short_vals = '{32'h7FFF_FFFE, 32'h8000_0000, 32'h0000_0003, 32'hFFFF_FFFE};
        zero_vals  = '{32'h1234_5678, 32'h8765_4321, 32'h0000_0000};
        sat_vals   = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                       32'hFFFF_FFFF};
        phase_len  = '{6'd32, 6'd1, 6'd63, 6'd9, 6'd0, 6'd2, 6'd40, 6'd16};
        phase_len[RAND_PHASES-1] = CFG_W'($urandom_range(63));

        // Synchronous reset, released at a falling clock edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        set_idle(IDLE_NONE);

        // Reset length of five with extremes; the window fills from zero and wraps
        foreach (edge_vals[i]) push_sample(edge_vals[i]);
        // Lower the length below the write position
        wait_drain();
        write_length(6'd2);
        foreach (short_vals[i]) push_sample(short_vals[i]);
        // Length zero acts as one
        wait_drain();
        write_length(6'd0);
        foreach (zero_vals[i]) push_sample(zero_vals[i]);
        // Length above the store depth saturates
        wait_drain();
        write_length(6'd63);
        foreach (sat_vals[i]) push_sample(sat_vals[i]);

        // Random phases, each with its own length and idle pattern
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drain();
            write_length(phase_len[ph]);
            set_idle(t_idle_mode'(ph % 4));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // in phase two, hold off once mid-phase until the filter has caught up
                if (ph == 2 && k == PHASE_ITEMS / 2) wait_drain();
                push_sample(rand_sample());
            end
        end

        wait_drain();
        repeat (SETTLE_CYC) @(negedge i_clk);

        $display("covered %0d samples and %0d medians over %0d length writes",
                 sb.n_samples, sb.n_checked, n_settings);
        $display("lengths 0 to 63 incl. saturation, wrap past a lowered length, %0d errors",
                 sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

endmodule
